// File: design/tgmst_pkg.sv
`default_nettype none
package tgmst_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int COORD_W = 16;
    localparam int SQ_W = 33;
    localparam int COST_W = 39;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SQ_W-1:0] sq_t;
endpackage
`default_nettype wire

// File: design/threshold_graph_min_spanning_tree.sv
// one round per tree node: source read, capture, one issue per point, pipe drain, one decision
// a set that falls apart stops after the first round that finds no link
// throughput: one non-last item per cycle; busy from the last item to the result strobe
// the result strobe lasts one cycle; the receiver cannot stall
// rst_n async low clears count, drop flag, threshold, control and results; memories keep data
`default_nettype none
module threshold_graph_min_spanning_tree import tgmst_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [COORD_W-1:0] x_coord,
    input  wire logic [COORD_W-1:0] y_coord,
    input  wire logic               last,
    input  wire logic               cfg_we,
    input  wire logic [SQ_W-1:0]    cfg_wdata,
    output logic                    done,
    output logic [COST_W-1:0]       total_cost,
    output logic                    connected,
    output logic                    overflowed
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRC   = 3'd1;
    localparam logic [2:0] ST_CAP   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    // point read (1) plus distance unit (3)
    localparam int PIPE = 4;

    logic [2:0] state_reg;
    cnt_t count_reg;
    logic drop_reg;
    sq_t min_sq_reg;

    // per-point tree and link-valid flags; link weights live in a memory
    logic [MAX_POINTS-1:0] in_tree_reg;
    logic [MAX_POINTS-1:0] has_link_reg;

    idx_t src_reg;       // point being relaxed from
    cnt_t scan_reg;      // issue index
    cnt_t added_reg;     // points already in the tree
    logic [PIPE-1:0] vld_pipe_reg;
    idx_t idx_pipe_reg [PIPE];
    logic best_found_reg;
    idx_t best_idx_reg;
    sq_t best_w_reg;
    logic [COST_W-1:0] sum_reg;
    logic [COORD_W-1:0] src_x_reg, src_y_reg;

    logic done_reg;
    logic [COST_W-1:0] total_cost_reg;
    logic connected_reg;
    logic overflowed_reg;

    logic accept;
    logic wr_en;
    logic issue;
    idx_t pt_raddr;
    logic [COORD_W-1:0] rx, ry;
    sq_t sq;
    sq_t link_rd;
    logic res_vld;
    idx_t res_idx;
    logic res_has;
    logic res_upd;
    logic res_cand;
    sq_t res_w;
    logic fin;
    logic fin_conn;

    assign busy = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign wr_en = accept && (count_reg < cnt_t'(MAX_POINTS));
    assign issue = state_reg == ST_SCAN;
    // source point read in its own cycle, otherwise the scan index
    assign pt_raddr = (state_reg == ST_SRC) ? src_reg : scan_reg[IDX_W-1:0];

    tgmst_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_xram (
        .clk(clk), .we(wr_en), .waddr(count_reg[IDX_W-1:0]), .wdata(x_coord),
        .raddr(pt_raddr), .rdata(rx));
    tgmst_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_yram (
        .clk(clk), .we(wr_en), .waddr(count_reg[IDX_W-1:0]), .wdata(y_coord),
        .raddr(pt_raddr), .rdata(ry));

    tgmst_dist u_dist (.clk(clk), .ax(src_x_reg), .ay(src_y_reg), .bx(rx), .by(ry),
        .sq(sq));

    // link weight read one stage early so it lines up with the distance;
    // each index is touched once per round, and rounds do not overlap
    tgmst_ram #(.WIDTH(SQ_W), .DEPTH(MAX_POINTS)) u_link_ram (
        .clk(clk), .we(res_upd), .waddr(res_idx), .wdata(sq),
        .raddr(idx_pipe_reg[PIPE-2]), .rdata(link_rd));

    // relax step and running minimum over the links after relaxing
    assign res_vld = vld_pipe_reg[PIPE-1];
    assign res_idx = idx_pipe_reg[PIPE-1];
    assign res_has = has_link_reg[res_idx];
    assign res_upd = res_vld && !in_tree_reg[res_idx] && (sq >= min_sq_reg)
        && (!res_has || sq < link_rd);
    assign res_w = res_upd ? sq : link_rd;
    assign res_cand = res_vld && !in_tree_reg[res_idx] && (res_upd || res_has)
        && (!best_found_reg || res_w < best_w_reg);

    // search ends: all points in the tree, or nothing left to reach
    assign fin_conn = added_reg >= count_reg;
    assign fin = (state_reg == ST_DRAIN) && (vld_pipe_reg == '0)
        && (fin_conn || !best_found_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg <= 1'b0;
            min_sq_reg <= '0;
            vld_pipe_reg <= '0;
            in_tree_reg <= '0;
            has_link_reg <= '0;
            src_reg <= '0;
            scan_reg <= '0;
            added_reg <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg <= '0;
            best_w_reg <= '0;
            sum_reg <= '0;
            src_x_reg <= '0;
            src_y_reg <= '0;
            done_reg <= 1'b0;
            total_cost_reg <= '0;
            connected_reg <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                min_sq_reg <= cfg_wdata;
            end
            vld_pipe_reg <= {vld_pipe_reg[PIPE-2:0], issue};
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (wr_en)
                        begin
                            count_reg <= count_reg + cnt_t'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            // tree starts from point 0
                            in_tree_reg <= MAX_POINTS'(1);
                            has_link_reg <= '0;
                            src_reg <= '0;
                            sum_reg <= '0;
                            added_reg <= cnt_t'(1);
                            best_found_reg <= 1'b0;
                            state_reg <= ST_SRC;
                        end
                    end
                end
                ST_SRC:
                begin
                    state_reg <= ST_CAP;
                end
                ST_CAP:
                begin
                    src_x_reg <= rx;
                    src_y_reg <= ry;
                    scan_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // one index issued per cycle
                    scan_reg <= scan_reg + cnt_t'(1);
                    if (scan_reg + cnt_t'(1) >= count_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (fin)
                    begin
                        done_reg <= 1'b1;
                        total_cost_reg <= fin_conn ? sum_reg : '0;
                        connected_reg <= fin_conn;
                        overflowed_reg <= drop_reg;
                        count_reg <= '0;
                        drop_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else if (vld_pipe_reg == '0)
                    begin
                        // nearest reachable point joins the tree
                        in_tree_reg[best_idx_reg] <= 1'b1;
                        sum_reg <= sum_reg + COST_W'(best_w_reg);
                        added_reg <= added_reg + cnt_t'(1);
                        src_reg <= best_idx_reg;
                        best_found_reg <= 1'b0;
                        state_reg <= ST_SRC;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (res_vld)
            begin
                if (res_upd)
                begin
                    has_link_reg[res_idx] <= 1'b1;
                end
                if (res_cand)
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg <= res_idx;
                    best_w_reg <= res_w;
                end
            end
        end
    end

    // index follows its point through the read and distance stages
    always_ff @(posedge clk)
    begin
        idx_pipe_reg[0] <= scan_reg[IDX_W-1:0];
        for (int i = 1; i < PIPE; i++)
        begin
            idx_pipe_reg[i] <= idx_pipe_reg[i-1];
        end
    end

    assign done = done_reg;
    assign total_cost = total_cost_reg;
    assign connected = connected_reg;
    assign overflowed = overflowed_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_IDLE) else $error("result outside idle");
    a_cost_conn: assert property (@(posedge clk) disable iff (!rst_n)
        done && !connected |-> total_cost == '0) else $error("cost on disconnect");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_POINTS)) else $error("count past capacity");
endmodule
`default_nettype wire

// File: design/tgmst_ram.sv
`default_nettype none
module tgmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: design/tgmst_dist.sv
`default_nettype none
module tgmst_dist import tgmst_pkg::*; (
    input  wire logic               clk,
    input  wire logic [COORD_W-1:0] ax,
    input  wire logic [COORD_W-1:0] ay,
    input  wire logic [COORD_W-1:0] bx,
    input  wire logic [COORD_W-1:0] by,
    output logic      [SQ_W-1:0]    sq
);
    // stage 1: differences, stage 2: squares, stage 3: sum
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [2*COORD_W-1:0] sx_reg, sy_reg;
    logic [SQ_W-1:0] sq_reg;
    always_ff @(posedge clk)
    begin
        dx_reg <= (ax >= bx) ? ax - bx : bx - ax;
        dy_reg <= (ay >= by) ? ay - by : by - ay;
        sx_reg <= dx_reg * dx_reg;
        sy_reg <= dy_reg * dy_reg;
        sq_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
    end
    assign sq = sq_reg;
endmodule
`default_nettype wire
